// ===== rtl/gtr_pkg.sv =====
//------------------------------------------------------------------------------
// gtr_pkg: shared types and constants of the glob-to-regex translator
// Holds the beat payload structs, the queue entry, the mode encoding and
// the character codes that the translator recognizes.
//------------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

  // Input beat: one raw glob character
  typedef struct packed {
    logic [7:0] pattern_char;
    logic       end_of_pattern;
  } gtr_in_t;

  // Result beat: one regex character or a bare end marker
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       pattern_done;
    logic       nest_overflow;
  } gtr_out_t;

  // Queue entry: the one or two results caused by one input character
  typedef struct packed {
    logic [7:0] char0;
    logic [7:0] char1;
    logic       two;
    logic       char_valid;
    logic       last;
    logic       overflow;
  } gtr_entry_t;

  typedef enum logic [1:0] {
    MODE_STREAM  = 2'd0,
    MODE_BRACKET = 2'd1,
    MODE_ESCAPE  = 2'd2
  } gtr_mode_t;

  // Bracket set progress
  localparam logic [1:0] SP_START  = 2'd0;
  localparam logic [1:0] SP_NEG    = 2'd1;
  localparam logic [1:0] SP_MEMBER = 2'd2;

  localparam int unsigned BD_W        = 5;
  localparam logic [BD_W-1:0] DEPTH_LIMIT = 5'd31;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_COLON   = 8'h3A;

endpackage

`default_nettype wire

// ===== rtl/gtr_front.sv =====
//------------------------------------------------------------------------------
// gtr_front: character classifier and translation state
// Accepts one glob character per cycle while the queue has room, updates the
// translation state and pushes any regex characters it causes into the queue.
//------------------------------------------------------------------------------
`default_nettype none

module gtr_front #(
  parameter int unsigned MAX_BRACE_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire gtr_pkg::gtr_in_t in_data,
  input  wire logic             q_full,
  output logic                  push,
  output gtr_pkg::gtr_entry_t   push_entry
);
  import gtr_pkg::*;

  gtr_mode_t            mode_r, mode_nxt, mode_step;
  logic [BD_W-1:0]      depth_r, depth_nxt;
  logic [MAX_BRACE_DEPTH-1:0] flags_r, flags_nxt;
  logic [1:0]           sp_r, sp_nxt;
  logic                 class_r, class_nxt;
  logic                 open_r, open_nxt;
  logic                 colon_r, colon_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic                 ovf_r, ovf_nxt, ovf_step;

  logic                 accept;
  logic [7:0]           c;
  logic                 last;
  logic [BD_W-1:0]      top_idx;
  logic                 top_flag;
  logic                 at_limit;
  logic                 prev_opens_alt;

  logic                 br_class_open, br_class_close, br_set_close, br_neg;

  logic [1:0]           n_emit;
  logic [7:0]           e0, e1;

  assign c        = in_data.pattern_char;
  assign last     = in_data.end_of_pattern;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign top_idx        = depth_r - 1'b1;
  assign at_limit       = depth_r >= BD_W'(MAX_BRACE_DEPTH);
  assign prev_opens_alt = (prev_r == CH_LBRACE) || (prev_r == CH_COMMA);

  // Flag of the innermost open level; levels beyond the stack read as zero
  always_comb begin
    top_flag = 1'b0;
    for (int i = 0; i < MAX_BRACE_DEPTH; i++) begin
      if (top_idx == BD_W'(i)) begin
        top_flag = flags_r[i];
      end
    end
  end

  // Bracket set decode, in priority order
  assign br_class_open  = open_r && (c == CH_COLON);
  assign br_class_close = !br_class_open && colon_r && (c == CH_RBRACK);
  assign br_set_close   = !br_class_open && !br_class_close &&
                          (c == CH_RBRACK) && (sp_r >= SP_MEMBER);
  assign br_neg         = !br_class_open && !br_class_close && !br_set_close &&
                          ((c == CH_BANG) || (c == CH_CARET)) && (sp_r == SP_START);

  // Next state
  always_comb begin
    mode_step = mode_r;
    depth_nxt = depth_r;
    flags_nxt = flags_r;
    sp_nxt    = sp_r;
    class_nxt = class_r;
    open_nxt  = open_r;
    colon_nxt = colon_r;
    ovf_step  = ovf_r;
    prev_nxt  = c;
    case (mode_r)
      MODE_BRACKET: begin
        open_nxt  = 1'b0;
        colon_nxt = 1'b0;
        if (br_class_open) begin
          class_nxt = 1'b1;
        end else if (br_class_close) begin
          class_nxt = 1'b0;
        end else if (br_set_close) begin
          mode_step = MODE_STREAM;
        end else if (br_neg) begin
          sp_nxt = SP_NEG;
        end else begin
          sp_nxt = SP_MEMBER;
          if (c == CH_LBRACK) begin
            open_nxt = 1'b1;
          end else if (class_r && (c == CH_COLON)) begin
            colon_nxt = 1'b1;
          end
        end
      end
      MODE_ESCAPE: begin
        mode_step = MODE_STREAM;
      end
      default: begin
        case (c)
          CH_LBRACE: begin
            if (at_limit) begin
              ovf_step = 1'b1;
            end
            for (int i = 0; i < MAX_BRACE_DEPTH; i++) begin
              if (depth_r == BD_W'(i)) begin
                flags_nxt[i] = 1'b0;
              end
            end
            if (depth_r < DEPTH_LIMIT) begin
              depth_nxt = depth_r + 1'b1;
            end
          end
          CH_COMMA: begin
            if ((depth_r != '0) && prev_opens_alt) begin
              for (int i = 0; i < MAX_BRACE_DEPTH; i++) begin
                if (top_idx == BD_W'(i)) begin
                  flags_nxt[i] = 1'b1;
                end
              end
            end
          end
          CH_RBRACE: begin
            if (depth_r != '0) begin
              depth_nxt = top_idx;
              for (int i = 0; i < MAX_BRACE_DEPTH; i++) begin
                if (top_idx == BD_W'(i)) begin
                  flags_nxt[i] = 1'b0;
                end
              end
            end
          end
          CH_LBRACK: begin
            mode_step = MODE_BRACKET;
            class_nxt = 1'b0;
            sp_nxt    = SP_START;
            open_nxt  = 1'b0;
            colon_nxt = 1'b0;
          end
          CH_BSLASH: begin
            mode_step = MODE_ESCAPE;
          end
          default: begin
          end
        endcase
      end
    endcase

    // Pattern end: return everything to its reset value
    mode_nxt = mode_step;
    ovf_nxt  = ovf_step;
    if (last) begin
      mode_nxt  = MODE_STREAM;
      depth_nxt = '0;
      flags_nxt = '0;
      sp_nxt    = SP_START;
      class_nxt = 1'b0;
      open_nxt  = 1'b0;
      colon_nxt = 1'b0;
      prev_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // Emitted characters
  always_comb begin
    n_emit = 2'd0;
    e0     = '0;
    e1     = '0;
    case (mode_r)
      MODE_BRACKET: begin
        n_emit = 2'd1;
        e0     = br_neg ? CH_CARET : c;
      end
      MODE_ESCAPE: begin
        if (c == CH_COMMA) begin
          n_emit = 2'd1;
          e0     = c;
        end else begin
          n_emit = 2'd2;
          e0     = CH_BSLASH;
          e1     = c;
        end
      end
      default: begin
        case (c)
          CH_CARET, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_DOT, CH_PLUS, CH_PIPE: begin
            n_emit = 2'd2;
            e0     = CH_BSLASH;
            e1     = c;
          end
          CH_LBRACE: begin
            n_emit = 2'd1;
            e0     = CH_LPAREN;
          end
          CH_COMMA: begin
            if (depth_r == '0) begin
              n_emit = 2'd1;
              e0     = c;
            end else if (!prev_opens_alt) begin
              n_emit = 2'd1;
              e0     = CH_PIPE;
            end
          end
          CH_RBRACE: begin
            if (depth_r != '0) begin
              n_emit = top_flag ? 2'd2 : 2'd1;
              e0     = CH_RPAREN;
              e1     = CH_QUEST;
            end else begin
              n_emit = 2'd2;
              e0     = CH_BSLASH;
              e1     = c;
            end
          end
          CH_STAR: begin
            n_emit = 2'd2;
            e0     = CH_DOT;
            e1     = CH_STAR;
          end
          CH_QUEST: begin
            n_emit = 2'd1;
            e0     = CH_DOT;
          end
          CH_BSLASH: begin
            n_emit = 2'd0;
          end
          default: begin
            n_emit = 2'd1;
            e0     = c;
          end
        endcase
      end
    endcase
    // Keep a trailing backslash
    if (last && (mode_step == MODE_ESCAPE)) begin
      n_emit = 2'd1;
      e0     = CH_BSLASH;
    end
  end

  assign push                  = accept && ((n_emit != 2'd0) || last);
  assign push_entry.char0      = e0;
  assign push_entry.char1      = e1;
  assign push_entry.two        = n_emit == 2'd2;
  assign push_entry.char_valid = n_emit != 2'd0;
  assign push_entry.last       = last;
  assign push_entry.overflow   = ovf_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STREAM;
      depth_r <= '0;
      flags_r <= '0;
      sp_r    <= SP_START;
      class_r <= 1'b0;
      open_r  <= 1'b0;
      colon_r <= 1'b0;
      prev_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      flags_r <= flags_nxt;
      sp_r    <= sp_nxt;
      class_r <= class_nxt;
      open_r  <= open_nxt;
      colon_r <= colon_nxt;
      prev_r  <= prev_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gtr_queue.sv =====
//------------------------------------------------------------------------------
// gtr_queue: short entry queue between classifier and emitter
// Small register FIFO so that each side stalls on its own.
//------------------------------------------------------------------------------
`default_nettype none

module gtr_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire gtr_pkg::gtr_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output gtr_pkg::gtr_entry_t      head
);
  import gtr_pkg::*;

  gtr_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = count_r == (QPTR_W+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underrun : assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("queue read while empty");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/gtr_back.sv =====
//------------------------------------------------------------------------------
// gtr_back: result emitter
// Splits each queue entry into one or two result beats and holds them in
// the output register until taken.
//------------------------------------------------------------------------------
`default_nettype none

module gtr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire gtr_pkg::gtr_entry_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gtr_pkg::gtr_out_t        out_data
);
  import gtr_pkg::*;

  logic      phase_r, phase_nxt;
  logic      out_valid_r, out_valid_nxt;
  gtr_out_t  out_data_r;
  gtr_out_t  result;
  logic      load;
  logic      final_beat;

  assign load       = head_valid && (!out_valid_r || out_ready);
  assign final_beat = phase_r || !head.two;
  assign pop        = load && final_beat;

  always_comb begin
    result.out_char      = phase_r ? head.char1 : head.char0;
    result.char_valid    = head.char_valid;
    result.pattern_done  = head.last && final_beat;
    result.nest_overflow = head.overflow;
  end

  always_comb begin
    phase_nxt     = load ? (head.two && !phase_r) : phase_r;
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_phase_two : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_valid && head.two))
    else $error("second half pending without a two-character entry");

  a_bare_is_done : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.char_valid) |-> out_data_r.pattern_done)
    else $error("bare result without pattern end");

  a_done_clears_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (load && result.pattern_done) |=> !phase_r)
    else $error("pattern end left a half-sent entry");

endmodule

`default_nettype wire

// ===== rtl/glob_to_regex_translator.sv =====
//------------------------------------------------------------------------------
// glob_to_regex_translator: streaming glob pattern to regex translator
// Path: an accepted input beat is written into the queue, and its first result
//   beat is then loaded from the queue head into the output register.
// Throughput: one input beat per cycle while the two-entry queue has room;
//   characters that expand to two regex characters give two beats at the
//   single-character result port, which sets the sustained rate.
// Reset: synchronous rst_n clears the translation state, queue and output.
//------------------------------------------------------------------------------
`default_nettype none

module glob_to_regex_translator #(
  parameter int unsigned MAX_BRACE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gtr_pkg::gtr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gtr_pkg::gtr_out_t      out_data
);
  import gtr_pkg::*;

  // Front to queue
  logic       push;
  gtr_entry_t push_entry;
  logic       q_full;

  // Queue to back
  logic       pop;
  logic       head_valid;
  gtr_entry_t head;

  // Front: classify each character against the mode, brace stack and
  // bracket-set look-ahead flags; push any output characters that it causes.
  gtr_front #(
    .MAX_BRACE_DEPTH (MAX_BRACE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple classification from the result port so a stall on
  // the output does not stop the front until the queue fills.
  gtr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: serialize each entry onto the result port, one beat per ready cycle,
  // marking the pattern end on the last beat of the final character.
  gtr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/tb_glob_to_regex_translator.sv =====
//------------------------------------------------------------------------------
// tb_glob_to_regex_translator: self-checking bench for the glob translator
// Streams glob patterns one character per beat and predicts every regex
// beat that each character causes. Each result beat is checked field by
// field against the oldest prediction, under bursty input and random
// result stalls.
//------------------------------------------------------------------------------
module tb_glob_to_regex_translator;
  timeunit 1ns;
  timeprecision 1ps;

  import gtr_pkg::*;

  localparam int MAX_NEST     = 16;
  localparam int RANDOM_BEATS = 1800;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 60;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  gtr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gtr_out_t out_data;

  glob_to_regex_translator #(
    .MAX_BRACE_DEPTH(MAX_NEST)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  //----------------------------------------------------------------------------
  // Pattern store and expected regex beats
  //----------------------------------------------------------------------------
  gtr_in_t  glob_beats[$];     // characters still to be sent
  gtr_out_t expected_regex[$]; // predicted result beats, oldest first
  int       beats_sent = 0;    // input beats put on the bus
  int       beats_in = 0;      // input beats accepted by the block
  int       results_seen = 0;
  int       error_count = 0;

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  //----------------------------------------------------------------------------
  // Translation predictor
  //----------------------------------------------------------------------------
  gtr_mode_t            tr_mode;
  logic [BD_W-1:0]      open_braces;
  logic [MAX_NEST-1:0]  optional_level;  // level had an empty alternative
  logic [1:0]           set_stage;
  logic                 in_class;
  logic                 bracket_open_seen;
  logic                 class_colon_seen;
  logic [7:0]           last_raw;
  logic                 overflow_flag;
  logic [7:0]           emit_chars[2];
  int                   emit_n;

  task automatic clear_translation_state();
    tr_mode           = MODE_STREAM;
    open_braces       = '0;
    optional_level    = '0;
    set_stage         = SP_START;
    in_class          = 1'b0;
    bracket_open_seen = 1'b0;
    class_colon_seen  = 1'b0;
    last_raw          = 8'h00;
    overflow_flag     = 1'b0;
  endtask

  // Append one regex character to this beat's output; at most two fit
  function automatic void emit_regex(input logic [7:0] ch);
    if (emit_n < 2) begin
      emit_chars[emit_n] = ch;
      emit_n++;
    end
  endfunction

  // Inside a bracket set: negation, literal ], [:class:] look-ahead
  task automatic predict_bracket(input logic [7:0] c);
    if (bracket_open_seen && c == CH_COLON) begin
      emit_regex(c);
      in_class          = 1'b1;
      bracket_open_seen = 1'b0;
      class_colon_seen  = 1'b0;
    end else if (class_colon_seen && c == CH_RBRACK) begin
      // closes the class, not the set
      emit_regex(c);
      in_class          = 1'b0;
      bracket_open_seen = 1'b0;
      class_colon_seen  = 1'b0;
    end else begin
      bracket_open_seen = 1'b0;
      class_colon_seen  = 1'b0;
      if (c == CH_RBRACK && set_stage >= SP_MEMBER) begin
        tr_mode = MODE_STREAM;
        emit_regex(c);
      end else if ((c == CH_BANG || c == CH_CARET) && set_stage == SP_START) begin
        emit_regex(CH_CARET);
        set_stage = SP_NEG;
      end else begin
        set_stage = SP_MEMBER;
        emit_regex(c);
        if (c == CH_LBRACK) begin
          bracket_open_seen = 1'b1;
        end else if (in_class && c == CH_COLON) begin
          class_colon_seen = 1'b1;
        end
      end
    end
  endtask

  // Outside sets: escapes, wildcards and brace alternation
  task automatic predict_stream(input logic [7:0] c);
    int level;
    case (c)
      CH_CARET, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_DOT, CH_PLUS, CH_PIPE: begin
        emit_regex(CH_BSLASH);
        emit_regex(c);
      end
      CH_LBRACE: begin
        if (int'(open_braces) >= MAX_NEST) begin
          overflow_flag = 1'b1;
        end else begin
          optional_level[open_braces] = 1'b0;
        end
        if (open_braces < DEPTH_LIMIT) begin
          open_braces = open_braces + 1'b1;
        end
        emit_regex(CH_LPAREN);
      end
      CH_COMMA: begin
        if (open_braces != 0) begin
          if (last_raw == CH_LBRACE || last_raw == CH_COMMA) begin
            // empty alternative: drop the pipe, mark the level optional
            level = int'(open_braces) - 1;
            if (level < MAX_NEST) begin
              optional_level[level] = 1'b1;
            end
          end else begin
            emit_regex(CH_PIPE);
          end
        end else begin
          emit_regex(c);
        end
      end
      CH_RBRACE: begin
        if (open_braces != 0) begin
          level = int'(open_braces) - 1;
          open_braces = open_braces - 1'b1;
          emit_regex(CH_RPAREN);
          if (level < MAX_NEST) begin
            if (optional_level[level]) begin
              emit_regex(CH_QUEST);
            end
            optional_level[level] = 1'b0;
          end
        end else begin
          emit_regex(CH_BSLASH);
          emit_regex(c);
        end
      end
      CH_LBRACK: begin
        tr_mode           = MODE_BRACKET;
        in_class          = 1'b0;
        set_stage         = SP_START;
        bracket_open_seen = 1'b0;
        class_colon_seen  = 1'b0;
        emit_regex(c);
      end
      CH_STAR: begin
        emit_regex(CH_DOT);
        emit_regex(CH_STAR);
      end
      CH_QUEST: begin
        emit_regex(CH_DOT);
      end
      CH_BSLASH: begin
        tr_mode = MODE_ESCAPE;
      end
      default: begin
        emit_regex(c);
      end
    endcase
  endtask

  // Work out the result beats of one accepted character and queue them
  task automatic predict_regex_beats(input gtr_in_t beat);
    logic [7:0] c;
    gtr_out_t   res;
    c = beat.pattern_char;
    emit_n = 0;
    if (tr_mode == MODE_BRACKET) begin
      predict_bracket(c);
    end else if (tr_mode == MODE_ESCAPE) begin
      // an escaped comma loses its backslash
      if (c != CH_COMMA) begin
        emit_regex(CH_BSLASH);
      end
      emit_regex(c);
      tr_mode = MODE_STREAM;
    end else begin
      predict_stream(c);
    end
    last_raw = c;
    // keep a trailing backslash
    if (beat.end_of_pattern && tr_mode == MODE_ESCAPE) begin
      emit_regex(CH_BSLASH);
    end
    for (int k = 0; k < emit_n; k++) begin
      res.out_char      = emit_chars[k];
      res.char_valid    = 1'b1;
      res.pattern_done  = beat.end_of_pattern && (k == emit_n - 1);
      res.nest_overflow = overflow_flag;
      expected_regex.insert(expected_regex.size(), res);
    end
    // a silent last character still closes the pattern with a bare marker
    if (beat.end_of_pattern && emit_n == 0) begin
      res.out_char      = 8'h00;
      res.char_valid    = 1'b0;
      res.pattern_done  = 1'b1;
      res.nest_overflow = overflow_flag;
      expected_regex.insert(expected_regex.size(), res);
    end
    if (beat.end_of_pattern) begin
      clear_translation_state();
    end
  endtask

  //----------------------------------------------------------------------------
  // Pattern builders
  //----------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c);
    gtr_in_t beat;
    beat.pattern_char   = c;
    beat.end_of_pattern = 1'b0;
    glob_beats.insert(glob_beats.size(), beat);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
    end
  endtask

  // Mark the most recent character as the last of its pattern
  task automatic close_pattern();
    gtr_in_t beat;
    if (glob_beats.size() != 0) begin
      beat = glob_beats[glob_beats.size() - 1];
      beat.end_of_pattern = 1'b1;
      glob_beats[glob_beats.size() - 1] = beat;
    end
  endtask

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Brace group with one to four alternatives, some of them empty
  task automatic push_brace_group();
    int alts;
    int width;
    push_char(CH_LBRACE);
    alts = $urandom_range(1, 3);
    for (int a = 0; a < alts; a++) begin
      if (a != 0) begin
        push_char(CH_COMMA);
      end
      width = $urandom_range(0, 3);
      for (int w = 0; w < width; w++) begin
        if ($urandom_range(0, 7) == 0) begin
          push_text("{b,}");
        end else begin
          push_char(pick_from("abxy*?.0"));
        end
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      push_char(CH_COMMA); // trailing empty alternative
    end
    push_char(CH_RBRACE);
  endtask

  // Bracket set with optional negation, literal ] and classes
  task automatic push_bracket_set();
    int members;
    int neg;
    push_char(CH_LBRACK);
    neg = $urandom_range(0, 3);
    if (neg == 0) begin
      push_char(CH_BANG);
    end else if (neg == 1) begin
      push_char(CH_CARET);
    end
    if ($urandom_range(0, 2) == 0) begin
      push_char(CH_RBRACK);
    end
    members = $urandom_range(0, 4);
    for (int m = 0; m < members; m++) begin
      case ($urandom_range(0, 5))
        0: push_text("[:alpha:]");
        1: push_text("[:d:");
        2: push_char(pick_from("[:^!-"));
        3: push_char(8'($urandom_range(0, 255)));
        default: push_char(pick_from("az09_"));
      endcase
    end
    push_char(CH_RBRACK);
  endtask

  // Brace nesting past the stack, sometimes up to the counter limit
  task automatic push_deep_nest();
    int depth;
    depth = $urandom_range(MAX_NEST + 1, 34);
    for (int d = 0; d < depth; d++) begin
      push_char(CH_LBRACE);
    end
    push_text("a,,");
    depth = $urandom_range(0, depth + 2);
    for (int d = 0; d < depth; d++) begin
      push_char(CH_RBRACE);
    end
  endtask

  task automatic push_random_pattern();
    int tokens;
    if ($urandom_range(0, 39) == 0) begin
      push_deep_nest();
    end else begin
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
        case ($urandom_range(0, 11))
          0, 1:  push_char(pick_from("abcmxyz019"));
          2:     push_char(8'($urandom_range(0, 255)));
          3:     push_char(pick_from("^$().+|*?:!"));
          4, 5:  push_brace_group();
          6, 7:  push_bracket_set();
          8: begin
            push_char(CH_BSLASH);
            if ($urandom_range(0, 2) == 0) begin
              push_char(CH_COMMA);
            end else begin
              push_char(pick_from("ab*?{}[],\\^"));
            end
          end
          9:     push_char(pick_from("},"));
          10:    push_char(pick_from("{[\\")); // opener left dangling
          default: push_char(8'($urandom_range(0, 255)));
        endcase
      end
      // now and then end on a lone backslash
      if ($urandom_range(0, 9) == 0) begin
        push_char(CH_BSLASH);
      end
    end
    close_pattern();
  endtask

  //----------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps, valid held until accepted
  //----------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    // hold the current beat while it is still waiting for ready
    if (rst_n && !(in_valid && beats_in != beats_sent)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (glob_beats.size() != 0) begin
        in_data  <= glob_beats.pop_front();
        in_valid <= 1'b1;
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          // some bursts run long with no gap at all
          if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left   = $urandom_range(1, 5);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  //----------------------------------------------------------------------------
  // Result-side stall pattern: a new random style for each random span of cycles
  //----------------------------------------------------------------------------
  int stall_style = 0;
  int stall_span = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_span == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_span  = $urandom_range(20, 200);
      end
      stall_span--;
      stall_tick++;
      case (stall_style)
        0: out_ready <= 1'b1;                          // never stall
        1: out_ready <= ($urandom_range(0, 9) > 2);    // light random stalls
        2: out_ready <= (stall_tick % 3 == 0);         // fixed periodic stalls
        default: out_ready <= ($urandom_range(0, 7) == 0); // heavy stalls
      endcase
    end
  end

  //----------------------------------------------------------------------------
  // Monitor: predict on accepted input beats, check accepted result beats
  //----------------------------------------------------------------------------
  always @(posedge clk) begin
    gtr_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_regex_beats(in_data);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_regex.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected: %03h",
                                    results_seen, out_data));
        end else begin
          want = expected_regex.pop_front();
          if (out_data.out_char !== want.out_char) begin
            report_mismatch($sformatf("result %0d out_char got %02h want %02h",
                                      results_seen, out_data.out_char, want.out_char));
          end
          if (out_data.char_valid !== want.char_valid) begin
            report_mismatch($sformatf("result %0d char_valid got %b want %b",
                                      results_seen, out_data.char_valid, want.char_valid));
          end
          if (out_data.pattern_done !== want.pattern_done) begin
            report_mismatch($sformatf("result %0d pattern_done got %b want %b",
                                      results_seen, out_data.pattern_done,
                                      want.pattern_done));
          end
          if (out_data.nest_overflow !== want.nest_overflow) begin
            report_mismatch($sformatf("result %0d nest_overflow got %b want %b",
                                      results_seen, out_data.nest_overflow,
                                      want.nest_overflow));
          end
        end
      end
    end
  end

  //----------------------------------------------------------------------------
  // Stimulus and end of run
  //----------------------------------------------------------------------------
  initial begin
    int directed_count;
    clear_translation_state();

    // every escaped special plus both wildcards
    push_text("*?^$().+|");
    close_pattern();
    // empty alternative: {,} becomes ()?
    push_text("{,}");
    close_pattern();
    // comma outside braces, unmatched close, top byte value
    push_text(",}");
    push_char(8'hFF);
    close_pattern();
    // negated set, literal ] after negation, [:class:] kept intact
    push_text("[^][:x:]]");
    close_pattern();
    // escaped comma drops its backslash, trailing backslash is kept
    push_text("\\,\\");
    close_pattern();
    // silent last character gives a bare end marker
    push_text("{,");
    close_pattern();
    push_char(8'h00);
    close_pattern();

    directed_count = glob_beats.size();
    while (glob_beats.size() < directed_count + RANDOM_BEATS) begin
      push_random_pattern();
    end

    // hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: all beats accepted, then every prediction matched
    while (glob_beats.size() != 0 || beats_in != beats_sent) begin
      @(posedge clk);
    end
    while (expected_regex.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_regex.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", expected_regex.size()));
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("TIMEOUT after %0d cycles, %0d beats still expected",
             cycle_count, expected_regex.size());
    $display("status: fail");
    $finish;
  end

endmodule
